// File: hdl/prmp_pkg.sv
// ---------------------------------------------------------------------------
// prmp_pkg: shared types and constants for the masked pixel packer
// Register indexes, channel format descriptor and the packing helpers.
// ---------------------------------------------------------------------------
package prmp_pkg;

   localparam int CHAN_W   = 8;
   localparam int WORD_W   = 16;
   localparam int ADDR_W   = 20;
   localparam int SIZE_W   = 11;
   localparam int SLOT_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RGB_W    = 3 * CHAN_W;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RED_MASK     = 3'd0,
      CSR_GREEN_MASK   = 3'd1,
      CSR_BLUE_MASK    = 3'd2,
      CSR_SOURCE_MODE  = 3'd3,
      CSR_IMAGE_WIDTH  = 3'd4,
      CSR_IMAGE_HEIGHT = 3'd5,
      CSR_LINE_PITCH   = 3'd6
   } csr_index_type;

   // input commands
   localparam logic CMD_PALETTE_WRITE = 1'b0;
   localparam logic CMD_PIXEL         = 1'b1;

   // source modes
   localparam logic MODE_PALETTE = 1'b0;
   localparam logic MODE_DIRECT  = 1'b1;

   // reset masks (rgb565)
   localparam logic [WORD_W-1:0] RED_MASK_RST   = 16'hF800;
   localparam logic [WORD_W-1:0] GREEN_MASK_RST = 16'h07E0;
   localparam logic [WORD_W-1:0] BLUE_MASK_RST  = 16'h001F;
   localparam logic [SIZE_W-1:0] PITCH_RST      = 11'd1024;

   // per-channel placement derived from a mask
   typedef struct packed {
      logic       en;      // mask not empty
      logic [2:0] rshift;  // 8 minus saturated bit count
      logic [3:0] lshift;  // lowest set bit
   } chan_fmt_type;

   // configuration seen by the datapath
   typedef struct packed {
      chan_fmt_type red;
      chan_fmt_type green;
      chan_fmt_type blue;
      logic         mode;
      logic [SIZE_W-1:0] pitch;
   } cfg_type;

   // mask to bit count and low shift
   function automatic chan_fmt_type decode_mask(input logic [WORD_W-1:0] mask);
      chan_fmt_type f;
      logic [4:0]   cnt;
      logic [3:0]   low;
      logic         found;
      cnt   = '0;
      low   = '0;
      found = 1'b0;
      for (int i = 0; i < WORD_W; i++) begin
         if (mask[i]) begin
            cnt = cnt + 5'd1;
            if (!found) begin
               low   = 4'(i);
               found = 1'b1;
            end
         end
      end
      if (cnt > 5'd8) begin
         cnt = 5'd8;
      end
      f.en     = (mask != '0);
      f.rshift = 3'(5'd8 - cnt);
      f.lshift = low;
      return f;
   endfunction

   // one channel's contribution to the surface word
   function automatic logic [WORD_W-1:0] chan_term(input logic [CHAN_W-1:0] chan,
                                                   input chan_fmt_type f);
      logic [WORD_W-1:0] v;
      v = {8'h00, chan >> f.rshift};
      return f.en ? (v << f.lshift) : '0;
   endfunction

endpackage

// File: hdl/prmp_if.sv
// ---------------------------------------------------------------------------
// prmp interfaces: request, response and register write channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ---------------------------------------------------------------------------
interface prmp_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] palette_slot;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, command, palette_slot, red, green, blue, input ready);
   modport sink   (input valid, command, palette_slot, red, green, blue, output ready);
endinterface

interface prmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] surface_word;
   logic [19:0] word_address;
   logic        last_pixel;

   modport source (output valid, surface_word, word_address, last_pixel, input ready);
   modport sink   (input valid, surface_word, word_address, last_pixel, output ready);
endinterface

interface prmp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/prmp_cfg.sv
// ---------------------------------------------------------------------------
// prmp_cfg: configuration registers
// Holds the decoded masks, mode, pitch and the clamped last column and row.
// ---------------------------------------------------------------------------
module prmp_cfg
   import prmp_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic            clock,
   input  logic            reset,
   prmp_csr_if.sink        csr_ch,
   output cfg_type         cfg,
   output logic [((MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1)-1:0] w_last,
   output logic [((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1)-1:0] h_last
);

   localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned W_LAST_RST = (1024 > MAX_WIDTH)  ? MAX_WIDTH  - 1 : 1023;
   localparam int unsigned H_LAST_RST = (1024 > MAX_HEIGHT) ? MAX_HEIGHT - 1 : 1023;

   cfg_type         cfg_ff;
   logic [CW-1:0]   w_last_ff;
   logic [RW-1:0]   h_last_ff;
   logic [SIZE_W-1:0] size_val;
   int unsigned     w_last_in;
   int unsigned     h_last_in;

   assign csr_ch.ready = 1'b1;
   assign size_val     = csr_ch.data[SIZE_W-1:0];

   // clamp size: zero reads as one, above the maximum saturates
   always_comb begin
      if (size_val == '0) begin
         w_last_in = 0;
      end else if (32'(size_val) > 32'(MAX_WIDTH)) begin
         w_last_in = MAX_WIDTH - 1;
      end else begin
         w_last_in = 32'(size_val) - 1;
      end
      if (size_val == '0) begin
         h_last_in = 0;
      end else if (32'(size_val) > 32'(MAX_HEIGHT)) begin
         h_last_in = MAX_HEIGHT - 1;
      end else begin
         h_last_in = 32'(size_val) - 1;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red   <= decode_mask(RED_MASK_RST);
         cfg_ff.green <= decode_mask(GREEN_MASK_RST);
         cfg_ff.blue  <= decode_mask(BLUE_MASK_RST);
         cfg_ff.mode  <= MODE_PALETTE;
         cfg_ff.pitch <= PITCH_RST;
         w_last_ff    <= CW'(W_LAST_RST);
         h_last_ff    <= RW'(H_LAST_RST);
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_RED_MASK:     cfg_ff.red   <= decode_mask(csr_ch.data);
            CSR_GREEN_MASK:   cfg_ff.green <= decode_mask(csr_ch.data);
            CSR_BLUE_MASK:    cfg_ff.blue  <= decode_mask(csr_ch.data);
            CSR_SOURCE_MODE:  cfg_ff.mode  <= csr_ch.data[0];
            CSR_IMAGE_WIDTH:  w_last_ff    <= CW'(w_last_in);
            CSR_IMAGE_HEIGHT: h_last_ff    <= RW'(h_last_in);
            CSR_LINE_PITCH:   cfg_ff.pitch <= size_val;
            default: begin
            end
         endcase
      end
   end

   assign cfg    = cfg_ff;
   assign w_last = w_last_ff;
   assign h_last = h_last_ff;

endmodule

// File: hdl/prmp_palette.sv
// ---------------------------------------------------------------------------
// prmp_palette: palette memory
// One address shared by the write and the read, read data registered and held when idle.
// ---------------------------------------------------------------------------
module prmp_palette
   import prmp_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic                              rd_en,
   input  logic [$clog2(PALETTE_DEPTH)-1:0]  addr,
   input  logic [RGB_W-1:0]                  wr_data,
   output logic [RGB_W-1:0]                  rd_data
);

   logic [RGB_W-1:0] mem [PALETTE_DEPTH];
   logic [RGB_W-1:0] rd_data_ff;

   // a read always follows any earlier write, so no bypass
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/prmp_pack.sv
// ---------------------------------------------------------------------------
// prmp_pack: pixel packing and address stage
// Selects the colour, packs the word, forms the address, output register.
// ---------------------------------------------------------------------------
module prmp_pack
   import prmp_pkg::*;
#(
   parameter int CW = 10,
   parameter int RW = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              load,
   input  logic              in_range,
   input  logic [RGB_W-1:0]  direct_rgb,
   input  logic [RW-1:0]     row_flip,
   input  logic [CW-1:0]     col,
   input  logic              last,
   input  logic [RGB_W-1:0]  pal_data,
   output logic              stage_free,
   prmp_rsp_if.source        rsp_ch
);

   localparam int PROD_W = RW + SIZE_W;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_in_range_ff;
   logic [RGB_W-1:0]  s1_rgb_ff;
   logic [RW-1:0]     s1_row_ff;
   logic [CW-1:0]     s1_col_ff;
   logic              s1_last_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              rsp_last_ff;

   logic              out_free;
   logic [RGB_W-1:0]  color;
   logic [WORD_W-1:0] word;
   logic [PROD_W-1:0] prod;
   logic [PROD_W:0]   sum;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign stage_free = !s1_valid_ff || out_free;

   // stage one valid
   always_comb begin
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_in_range_ff <= in_range;
         s1_rgb_ff      <= direct_rgb;
         s1_row_ff      <= row_flip;
         s1_col_ff      <= col;
         s1_last_ff     <= last;
      end
   end

   // colour select and packing
   always_comb begin
      if (cfg.mode == MODE_DIRECT) begin
         color = s1_rgb_ff;
      end else if (s1_in_range_ff) begin
         color = pal_data;
      end else begin
         color = '0;
      end
      word = chan_term(color[23:16], cfg.red) |
             chan_term(color[15:8],  cfg.green) |
             chan_term(color[7:0],   cfg.blue);
   end

   // flipped row times pitch plus column
   assign prod = PROD_W'(s1_row_ff) * PROD_W'(cfg.pitch);
   assign sum  = (PROD_W+1)'(prod) + (PROD_W+1)'(s1_col_ff);

   // output register
   always_comb begin
      if (s1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_free) begin
         rsp_word_ff <= word;
         rsp_addr_ff <= ADDR_W'(sum);
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.surface_word = rsp_word_ff;
   assign rsp_ch.word_address = rsp_addr_ff;
   assign rsp_ch.last_pixel   = rsp_last_ff;

endmodule

// File: hdl/palette_or_rgb_to_masked_pixel.sv
// ---------------------------------------------------------------------------
// palette_or_rgb_to_masked_pixel: palette or rgb to masked 16-bit pixel
// Throughput: one item per cycle while rsp is not stalled; the palette read
//   takes one stage, packing and the address multiply share the next (the
//   output register), the raster counters update at transfer.
// Reset: counters zero, registers to rgb565 1024x1024, pitch 1024, palette
//   mode; the palette memory is not cleared and holds garbage until written.
// ---------------------------------------------------------------------------
module palette_or_rgb_to_masked_pixel
   import prmp_pkg::*;
#(
   parameter int MAX_WIDTH     = 1024,
   parameter int MAX_HEIGHT    = 1024,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   prmp_req_if.sink    req_ch,
   prmp_rsp_if.source  rsp_ch,
   prmp_csr_if.sink    csr_ch
);

   localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int PW = $clog2(PALETTE_DEPTH);

   cfg_type          cfg;
   logic [CW-1:0]    w_last;
   logic [RW-1:0]    h_last;
   logic [CW-1:0]    col_ff, col_in, col_eff;
   logic [RW-1:0]    row_ff, row_in, row_eff;
   logic [RW-1:0]    row_flip;
   logic             last;
   logic             stage_free;
   logic             xfer;
   logic             pix_xfer;
   logic             in_range;
   logic [RGB_W-1:0] rgb;
   logic [RGB_W-1:0] pal_data;

   assign xfer     = req_ch.valid && req_ch.ready;
   assign pix_xfer = xfer && (req_ch.command == CMD_PIXEL);
   assign in_range = (32'(req_ch.palette_slot) < 32'(PALETTE_DEPTH));
   assign rgb      = {req_ch.red, req_ch.green, req_ch.blue};
   assign req_ch.ready = stage_free;

   prmp_cfg #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg),
      .w_last (w_last),
      .h_last (h_last)
   );

   prmp_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (xfer && (req_ch.command == CMD_PALETTE_WRITE) && in_range),
      .rd_en   (pix_xfer),
      .addr    (req_ch.palette_slot[PW-1:0]),
      .wr_data (rgb),
      .rd_data (pal_data)
   );

   // raster position, saturated if the image shrank mid-stream
   always_comb begin
      col_eff  = (col_ff > w_last) ? w_last : col_ff;
      row_eff  = (row_ff > h_last) ? h_last : row_ff;
      row_flip = h_last - row_eff;
      last     = (col_eff == w_last) && (row_eff == h_last);
      if (col_eff == w_last) begin
         col_in = '0;
         row_in = (row_eff == h_last) ? '0 : row_eff + RW'(1);
      end else begin
         col_in = col_eff + CW'(1);
         row_in = row_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (pix_xfer) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   prmp_pack #(
      .CW (CW),
      .RW (RW)
   ) u_pack (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .load       (pix_xfer),
      .in_range   (in_range),
      .direct_rgb (rgb),
      .row_flip   (row_flip),
      .col        (col_eff),
      .last       (last),
      .pal_data   (pal_data),
      .stage_free (stage_free),
      .rsp_ch     (rsp_ch)
   );

endmodule
